/* hw/rtl/dq_pkg.sv */
package dq_pkg;

  typedef logic [2:0]        mode_t;
  typedef logic signed [31:0] word_t;
  typedef logic [1:0]        status_t;

  // operation codes carried in the mode field
  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_REAR  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_REAR   = 3'd3;
  localparam mode_t MODE_LIST       = 3'd4;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // per-cycle command broadcast along the chain, at most one bit set
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
    logic rotate;
  } cell_ctl_t;

endpackage

/* hw/rtl/dq_in_if.sv */
interface dq_in_if;
  import dq_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  word_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);

endinterface

/* hw/rtl/dq_out_if.sv */
interface dq_out_if;
  import dq_pkg::*;

  logic    valid;
  logic    ready;
  word_t   word;
  status_t status;
  logic    last;

  modport source (output valid, output word, output status, output last, input ready);
  modport sink   (input valid, input word, input status, input last, output ready);

endinterface

/* hw/rtl/dq_cell.sv */
module dq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dq_pkg::cell_ctl_t ctl,
  input  dq_pkg::word_t     push_word,
  input  dq_pkg::word_t     prev_word,
  input  logic              prev_valid,
  input  dq_pkg::word_t     next_word,
  input  logic              next_valid,
  input  dq_pkg::word_t     head_word,
  output dq_pkg::word_t     word_r,
  output logic              valid_r,
  output logic              is_rear
);
  import dq_pkg::*;

  word_t word_nxt;
  logic  valid_nxt;

  // this cell holds the rear word of the queue
  assign is_rear = valid_r && !next_valid;

  // next contents from the neighbours, the input word or the front word
  always_comb begin
    word_nxt  = word_r;
    valid_nxt = valid_r;
    if (ctl.push_front) begin
      word_nxt  = prev_word;
      valid_nxt = prev_valid;
    end else if (ctl.push_rear) begin
      if (!valid_r && prev_valid) begin
        word_nxt  = push_word;
        valid_nxt = 1'b1;
      end
    end else if (ctl.pop_front) begin
      word_nxt  = next_word;
      valid_nxt = next_valid;
    end else if (ctl.pop_rear) begin
      valid_nxt = valid_r && next_valid;
    end else if (ctl.rotate) begin
      word_nxt = is_rear ? head_word : next_word;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stored word
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

/* hw/rtl/double_ended_queue.sv */
// Bounded double-ended queue of signed 32-bit words.
// in_ch carries a mode (push front, push rear, pop front, pop rear, list)
// and a value; out_ch returns word, status and last, all valid/ready words.
// Storage is a row of DEPTH cells, front word in the first cell, each cell
// loading from its left or right neighbour as the queue shifts.
// Push and pop: one input word per cycle while out_ch takes each result;
// result registered and shown on out_ch the cycle after acceptance.
// List: input accepted, then one result per cycle while out_ch is ready,
// front to rear, as the chain rotates by one cell per result; after
// occupancy rotations the order is back where it started. in_ch is not
// ready while a list is in progress. An empty list, a pop on an empty
// queue and a push on a full queue give a single result, status empty or full.
// Unused modes are accepted and produce nothing.
// Reset clears all cell flags and the count: the queue starts empty; no
// clearing pass is needed.
// When out_ch stalls, the result register holds and in_ch drops ready until
// the pending word is taken; a word is accepted in the same cycle the
// previous result leaves.
module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  cell_ctl_t        ctl;
  word_t            cell_word [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_rear;
  word_t            prev_word [DEPTH];
  logic [DEPTH-1:0] prev_valid;
  word_t            next_word [DEPTH];
  logic [DEPTH-1:0] next_valid;
  word_t            rear_word;

  logic [CW-1:0] occ_r, occ_nxt;
  logic          list_busy_r, list_busy_nxt;
  logic [CW-1:0] list_left_r, list_left_nxt;

  logic    out_valid_r, out_valid_nxt;
  word_t   out_word_r, out_word_nxt;
  status_t out_status_r, out_status_nxt;
  logic    out_last_r, out_last_nxt;

  logic in_fire;
  logic out_free;
  logic is_full;
  logic is_empty;

  // chain of cells, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_word[i]  = in_ch.value;
      assign prev_valid[i] = 1'b1;
    end else begin : g_inner_prev
      assign prev_word[i]  = cell_word[i-1];
      assign prev_valid[i] = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_word[i]  = '0;
      assign next_valid[i] = 1'b0;
    end else begin : g_inner_next
      assign next_word[i]  = cell_word[i+1];
      assign next_valid[i] = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .push_word  (in_ch.value),
      .prev_word  (prev_word[i]),
      .prev_valid (prev_valid[i]),
      .next_word  (next_word[i]),
      .next_valid (next_valid[i]),
      .head_word  (cell_word[0]),
      .word_r     (cell_word[i]),
      .valid_r    (cell_valid[i]),
      .is_rear    (cell_rear[i])
    );
  end

  // rear word picked by the one-hot rear flags
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | (cell_word[i] & {32{cell_rear[i]}});
    end
  end

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !list_busy_r && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_full     = (occ_r == FULL_CNT);
  assign is_empty    = (occ_r == '0);

  // command decode and result formation
  always_comb begin
    ctl            = '0;
    occ_nxt        = occ_r;
    list_busy_nxt  = list_busy_r;
    list_left_nxt  = list_left_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    if (list_busy_r && out_free) begin
      // list in progress: front word out, chain rotates by one
      ctl.rotate     = 1'b1;
      out_valid_nxt  = 1'b1;
      out_word_nxt   = cell_word[0];
      out_status_nxt = ST_OK;
      out_last_nxt   = (list_left_r == ONE_CNT);
      list_left_nxt  = list_left_r - ONE_CNT;
      list_busy_nxt  = (list_left_r != ONE_CNT);
    end else if (in_fire) begin
      out_word_nxt   = '0;
      out_status_nxt = ST_OK;
      out_last_nxt   = 1'b1;
      case (in_ch.mode)
        MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
          out_valid_nxt = 1'b1;
          if (is_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            ctl.push_front = (in_ch.mode == MODE_PUSH_FRONT);
            ctl.push_rear  = (in_ch.mode == MODE_PUSH_REAR);
            occ_nxt        = occ_r + ONE_CNT;
          end
        end
        MODE_POP_FRONT, MODE_POP_REAR: begin
          out_valid_nxt = 1'b1;
          if (is_empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            ctl.pop_front = (in_ch.mode == MODE_POP_FRONT);
            ctl.pop_rear  = (in_ch.mode == MODE_POP_REAR);
            out_word_nxt  = (in_ch.mode == MODE_POP_FRONT) ? cell_word[0] : rear_word;
            occ_nxt       = occ_r - ONE_CNT;
          end
        end
        MODE_LIST: begin
          if (is_empty) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
          end else begin
            list_busy_nxt = 1'b1;
            list_left_nxt = occ_r;
          end
        end
        default: begin
          // unused modes leave everything as is
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      list_busy_r <= 1'b0;
      list_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      list_busy_r <= list_busy_nxt;
      list_left_r <= list_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.word   = out_word_r;
  assign out_ch.status = out_status_r;
  assign out_ch.last   = out_last_r;

`ifndef SYNTHESIS
  // count never passes the number of cells
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy beyond depth");

  // count agrees with the cell flags
  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(occ_r))
    else $error("occupancy and cell flags disagree");

  // occupied cells form one block from the front
  a_front_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("gap in occupied cells");

  // list counter stays within the stored words
  a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
    list_busy_r |-> (list_left_r != '0) && (list_left_r <= occ_r))
    else $error("list counter out of range");

  // rotation leaves the cell flags untouched
  a_rotate_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rotate |=> $stable(cell_valid))
    else $error("cell flags changed during list");
`endif

endmodule
